>>> design/assert_macros.svh
// Assertion macros used by the selector datapath.
// Each expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define TKFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define TKFS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> design/tkfs_pkg.sv
// Package for the top-k fitness selector: sizes, constants and the
// command / status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tkfs_pkg;

  localparam int MAX_ENTRIES  = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int IDX_W        = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int KEEP_W       = 6;
  localparam int RUN_W        = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
  localparam int FIT_W        = 32;
  localparam int SRC_W        = 5;
  localparam int KEEP_RESET   = 10;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_run;
    logic emit;
  } tkfs_cmd_t;

  typedef struct packed {
    logic keep_zero;
    logic scan_done;
    logic out_free;
    logic rank_last;
  } tkfs_status_t;

endpackage

>>> design/tkfs_if.sv
// Valid/ready channel interfaces for the selector: entry beats in, rank beats out.
// Depends on tkfs_pkg for field widths.
`timescale 1ns / 1ps

interface tkfs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tkfs_pkg::FIT_W-1:0]   fitness_value;
  logic                                last_entry;

  modport source (output valid, output fitness_value, output last_entry, input ready);
  modport sink   (input valid, input fitness_value, input last_entry, output ready);
endinterface

interface tkfs_out_if;
  logic                                valid;
  logic                                ready;
  logic        [tkfs_pkg::SRC_W-1:0]   source_index;
  logic signed [tkfs_pkg::FIT_W-1:0]   selected_fitness;
  logic                                last_rank;

  modport source (output valid, output source_index, output selected_fitness,
                  output last_rank, input ready);
  modport sink   (input valid, input source_index, input selected_fitness,
                  input last_rank, output ready);
endinterface

>>> design/top_k_fitness_selector_core.sv
// Top level of the top-k fitness selector: controller plus datapath.
// Depends on tkfs_pkg, tkfs_if, tkfs_ctrl and tkfs_datapath.
//
//   channel  dir  handshake            payload
//   entry    in   valid / ready        fitness_value[31:0] signed, last_entry
//   ranked   out  valid / ready        source_index[4:0], selected_fitness[31:0], last_rank
//   cfg      in   cfg_wr_en            cfg_wr_data[5:0] -> keep_count
//
// Loading takes one entry beat per cycle while entry ready is high; a non-last beat gives no result.
// Each rank takes one RAM read per entry through the single read port, with registered
// read data, and then a move of the winner into the output register.
// Entry beats are refused while ranks are being scanned; the output register holds a
// rank while the next scan runs, and a scan waits on the output only to emit.
// Reset clears the count, taken mask and control state and sets keep_count to 10.
`timescale 1ns / 1ps

module top_k_fitness_selector_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tkfs_pkg::KEEP_W-1:0] cfg_wr_data,
  tkfs_in_if.sink                     entry,
  tkfs_out_if.source                  ranked
);

  tkfs_pkg::tkfs_cmd_t    cmd;
  tkfs_pkg::tkfs_status_t status;

  tkfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (entry.valid),
    .in_last  (entry.last_entry),
    .in_ready (entry.ready),
    .cmd      (cmd),
    .status   (status)
  );

  tkfs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fitness  (entry.fitness_value),
    .in_last     (entry.last_entry),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (ranked.valid),
    .out_ready   (ranked.ready),
    .out_index   (ranked.source_index),
    .out_fitness (ranked.selected_fitness),
    .out_last    (ranked.last_rank)
  );

endmodule

>>> design/tkfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tkfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/tkfs_ctrl.sv
// Controller for the selector: load / scan state machine issuing datapath commands.
// Depends on tkfs_pkg.
`timescale 1ns / 1ps

module tkfs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  output tkfs_pkg::tkfs_cmd_t    cmd,
  input  tkfs_pkg::tkfs_status_t status
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic state_next;

  assign in_ready = (state == ST_LOAD);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_LOAD: begin
        cmd.accept = in_valid;
        if (in_valid && in_last && !status.keep_zero) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done && status.out_free) begin
          cmd.emit = 1'b1;
          if (status.rank_last) begin
            state_next = ST_LOAD;
          end else begin
            cmd.scan_start = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/tkfs_datapath.sv
// Datapath for the selector: fitness store, taken mask, max scan and output register.
// Depends on tkfs_pkg, tkfs_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tkfs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [tkfs_pkg::KEEP_W-1:0]        cfg_wr_data,
  input  logic signed [tkfs_pkg::FIT_W-1:0]  in_fitness,
  input  logic                               in_last,
  input  tkfs_pkg::tkfs_cmd_t                cmd,
  output tkfs_pkg::tkfs_status_t             status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tkfs_pkg::SRC_W-1:0]         out_index,
  output logic signed [tkfs_pkg::FIT_W-1:0]  out_fitness,
  output logic                               out_last
);

  logic [tkfs_pkg::CNT_W-1:0]        count;
  logic [tkfs_pkg::CNT_W-1:0]        count_new;
  logic                              room;
  logic [tkfs_pkg::MAX_ENTRIES-1:0]  mask;
  logic [tkfs_pkg::KEEP_W-1:0]       keep;
  logic [tkfs_pkg::RUN_W-1:0]        runs;
  logic [tkfs_pkg::RUN_W-1:0]        runs_next;
  logic [tkfs_pkg::RUN_W-1:0]        rank;
  logic [tkfs_pkg::CNT_W-1:0]        addr;
  logic                              rd_vld;
  logic [tkfs_pkg::IDX_W-1:0]        rd_idx;
  logic [tkfs_pkg::FIT_W-1:0]        rd_data;
  logic                              found;
  logic [tkfs_pkg::IDX_W-1:0]        best_idx;
  logic signed [tkfs_pkg::FIT_W-1:0] best_fit;
  logic                              take_rd;
  logic                              rank_last;

  tkfs_ram #(
    .WIDTH (tkfs_pkg::FIT_W),
    .DEPTH (tkfs_pkg::MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && room),
    .waddr (count[tkfs_pkg::IDX_W-1:0]),
    .wdata (in_fitness),
    .raddr (addr[tkfs_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign room      = count < tkfs_pkg::CNT_W'(tkfs_pkg::MAX_ENTRIES);
  assign count_new = count + tkfs_pkg::CNT_W'(room);
  assign take_rd   = rd_vld && !mask[rd_idx] && (!found || ($signed(rd_data) > best_fit));
  assign rank_last = (tkfs_pkg::RUN_W'(rank + 1'b1) == runs);

  always_comb begin
    runs_next = tkfs_pkg::RUN_W'(keep);
    if (runs_next > tkfs_pkg::RUN_W'(count_new)) begin
      runs_next = tkfs_pkg::RUN_W'(count_new);
    end
    if (runs_next > tkfs_pkg::RUN_W'(tkfs_pkg::RESULT_LIMIT)) begin
      runs_next = tkfs_pkg::RUN_W'(tkfs_pkg::RESULT_LIMIT);
    end
  end

  assign status.keep_zero = (keep == '0);
  assign status.scan_done = (addr == count) && !rd_vld;
  assign status.out_free  = !out_valid || out_ready;
  assign status.rank_last = rank_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      mask      <= '0;
      keep      <= tkfs_pkg::KEEP_W'(tkfs_pkg::KEEP_RESET);
      runs      <= '0;
      rank      <= '0;
      addr      <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        keep <= cfg_wr_data;
      end
      if (cmd.accept) begin
        if (count == '0) begin
          mask <= '0;
        end else if (room) begin
          mask[count[tkfs_pkg::IDX_W-1:0]] <= 1'b0;
        end
        if (in_last) begin
          runs  <= runs_next;
          rank  <= '0;
          count <= (keep == '0) ? '0 : count_new;
        end else begin
          count <= count_new;
        end
      end
      if (cmd.scan_start) begin
        addr   <= '0;
        rd_vld <= 1'b0;
        found  <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_vld <= (addr < count);
        if (addr < count) begin
          addr <= addr + 1'b1;
        end
        if (take_rd) begin
          found <= 1'b1;
        end
      end
      if (cmd.emit) begin
        mask[best_idx] <= 1'b1;
        rank           <= rank + 1'b1;
        out_valid      <= 1'b1;
        if (rank_last) begin
          count <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= addr[tkfs_pkg::IDX_W-1:0];
    if (take_rd) begin
      best_idx <= rd_idx;
      best_fit <= $signed(rd_data);
    end
    if (cmd.emit) begin
      out_index   <= tkfs_pkg::SRC_W'(best_idx);
      out_fitness <= best_fit;
      out_last    <= rank_last;
    end
  end

  `TKFS_ASSERT(a_emit_after_scan, cmd.emit |-> (found && status.scan_done), "emit before scan completed")
  `TKFS_ASSERT_NEXT(a_winner_taken, cmd.emit, mask[$past(best_idx)], "winner not marked taken")
  `TKFS_ASSERT(a_read_in_set, rd_vld |-> (tkfs_pkg::CNT_W'(rd_idx) < count), "scan read beyond set")

endmodule

>>> verif/top_k_fitness_selector_core_tb.sv
// Self-checking testbench for top_k_fitness_selector_core: loads sets of signed
// fitness beats and checks every ranked beat against a predictor of the selection or a typed rank.
// Depends on tkfs_pkg, tkfs_if and the selector RTL.
`timescale 1ns / 1ps

module top_k_fitness_selector_core_tb;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int SET_BEATS     = 22;
  localparam int N_ROWS        = 22;
  localparam int N_PHASES      = 8;

  typedef struct packed {
    logic [tkfs_pkg::SRC_W-1:0]        idx;
    logic signed [tkfs_pkg::FIT_W-1:0] fit;
    logic                              last;
  } rank_t;

  typedef enum logic [0:0] {ROW_BEAT, ROW_KEEP} row_kind_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [tkfs_pkg::KEEP_W-1:0] keep;
    logic [tkfs_pkg::FIT_W-1:0]  fit;
    logic                        last;
    chk_t                        chk;
    rank_t                       typed;
  } row_t;

  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    '{ROW_BEAT, 6'd0,  32'h7FFF_FFFF, 1'b1, CHK_ONE,     '{5'd0, 32'h7FFF_FFFF, 1'b1}},
    '{ROW_BEAT, 6'd0,  32'h8000_0000, 1'b1, CHK_ONE,     '{5'd0, 32'h8000_0000, 1'b1}},
    '{ROW_BEAT, 6'd0,  32'h0000_0000, 1'b1, CHK_ONE,     '{5'd0, 32'h0000_0000, 1'b1}},
    '{ROW_BEAT, 6'd0,  32'h0001_0000, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h0001_0000, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h0001_0000, 1'b1, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h7FFF_FFFF, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h8000_0000, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'hFFFF_0000, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h0000_8000, 1'b1, CHK_PREDICT, '0},
    '{ROW_KEEP, 6'd1,  32'h0000_0000, 1'b0, CHK_NONE,    '0},
    '{ROW_BEAT, 6'd0,  32'h0005_0000, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h7FFF_FFFF, 1'b1, CHK_ONE,     '{5'd1, 32'h7FFF_FFFF, 1'b1}},
    '{ROW_KEEP, 6'd0,  32'h0000_0000, 1'b0, CHK_NONE,    '0},
    '{ROW_BEAT, 6'd0,  32'h0001_0000, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h0002_0000, 1'b1, CHK_NONE,    '0},
    '{ROW_KEEP, 6'd63, 32'h0000_0000, 1'b0, CHK_NONE,    '0},
    '{ROW_BEAT, 6'd0,  32'hFFFF_FFFF, 1'b1, CHK_ONE,     '{5'd0, 32'hFFFF_FFFF, 1'b1}},
    '{ROW_KEEP, 6'd2,  32'h0000_0000, 1'b0, CHK_NONE,    '0},
    '{ROW_BEAT, 6'd0,  32'h8000_0000, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h8000_0000, 1'b0, CHK_PREDICT, '0},
    '{ROW_BEAT, 6'd0,  32'h8000_0001, 1'b1, CHK_PREDICT, '0}
  };

  localparam logic [tkfs_pkg::KEEP_W-1:0] PHASE_KEEP [N_PHASES] = '{
    6'd32, 6'd5, 6'd1, 6'd63, 6'd0, 6'd17, 6'd3, 6'd10
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [tkfs_pkg::KEEP_W-1:0] cfg_wr_data;

  tkfs_in_if  entry_if ();
  tkfs_out_if ranked_if ();

  top_k_fitness_selector_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .entry       (entry_if),
    .ranked      (ranked_if)
  );

  // Selection predictor state
  logic signed [tkfs_pkg::FIT_W-1:0] fit_store [tkfs_pkg::MAX_ENTRIES];
  logic [tkfs_pkg::MAX_ENTRIES-1:0]  taken;
  int                                set_count;
  logic [tkfs_pkg::KEEP_W-1:0]       keep_setting;
  rank_t                             pick_buf [tkfs_pkg::RESULT_LIMIT];

  rank_t expected_ranks [$];

  bit hold_request;
  bit no_idle;
  int mismatch_count;
  int ranks_checked;
  int beats_sent;
  int sets_sent;
  int dropped_beats;
  int keeps_written;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic predict_entry(input logic signed [tkfs_pkg::FIT_W-1:0] fit,
                               input logic last_in, output int n_picks);
    int runs;
    int best;
    bit found;
    n_picks = 0;
    if (set_count == 0) taken = '0;
    if (set_count < tkfs_pkg::MAX_ENTRIES) begin
      fit_store[set_count] = fit;
      taken[set_count] = 1'b0;
      set_count++;
    end else begin
      dropped_beats++;
    end
    if (last_in) begin
      runs = int'(keep_setting);
      if (runs > set_count) runs = set_count;
      if (runs > tkfs_pkg::RESULT_LIMIT) runs = tkfs_pkg::RESULT_LIMIT;
      for (int r = 0; r < runs; r++) begin
        found = 1'b0;
        best = 0;
        for (int j = 0; j < set_count; j++) begin
          if (!taken[j] && (!found || fit_store[j] > fit_store[best])) begin
            found = 1'b1;
            best = j;
          end
        end
        taken[best] = 1'b1;
        pick_buf[r] = '{best[tkfs_pkg::SRC_W-1:0], fit_store[best], (r == runs - 1)};
      end
      n_picks = runs;
      set_count = 0;
    end
  endtask

  // Entered and left at a falling edge with nothing yet driven in that step
  task automatic send_beat(input logic signed [tkfs_pkg::FIT_W-1:0] fit,
                           input logic last_in, input chk_t chk, input rank_t typed);
    int n;
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      entry_if.valid <= 1'b0;
      @(negedge clk);
    end
    entry_if.valid         <= 1'b1;
    entry_if.fitness_value <= fit;
    entry_if.last_entry    <= last_in;
    @(posedge clk);
    while (!entry_if.ready) @(posedge clk);
    predict_entry(fit, last_in, n);
    case (chk)
      CHK_PREDICT: for (int k = 0; k < n; k++) expected_ranks.push_back(pick_buf[k]);
      CHK_ONE:     expected_ranks.push_back(typed);
      default:     ;
    endcase
    beats_sent++;
    if (last_in) sets_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    entry_if.valid <= 1'b0;
    while (expected_ranks.size() != 0) @(negedge clk);
  endtask

  task automatic write_keep(input logic [tkfs_pkg::KEEP_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    keep_setting = value;
    keeps_written++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Ranked-side ready: random idling, a long hold-off on request
  initial begin
    ranked_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        ranked_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      ranked_if.ready <= !rst && (no_idle || $urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin
    rank_t got;
    rank_t want;
    if (!rst && ranked_if.valid && ranked_if.ready) begin
      got = '{ranked_if.source_index, ranked_if.selected_fitness, ranked_if.last_rank};
      ranks_checked++;
      if (expected_ranks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected rank beat idx=%0d fit=%h last=%b", $realtime,
                   got.idx, got.fit, got.last);
      end else begin
        want = expected_ranks.pop_front();
        if (got.idx !== want.idx || got.fit !== want.fit || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: rank mismatch exp idx=%0d fit=%h last=%b got idx=%0d fit=%h last=%b",
                     $realtime, want.idx, want.fit, want.last, got.idx, got.fit, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (entry_if.valid && entry_if.ready) || (ranked_if.valid && ranked_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles, %0d ranks outstanding",
                 stall_cycles, expected_ranks.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int sel;
    int phase_beats;
    logic signed [tkfs_pkg::FIT_W-1:0] fit;
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    entry_if.valid         = 1'b0;
    entry_if.fitness_value = '0;
    entry_if.last_entry    = 1'b0;
    hold_request           = 1'b0;
    no_idle                = 1'b0;
    taken                  = '0;
    set_count              = 0;
    keep_setting           = tkfs_pkg::KEEP_W'(tkfs_pkg::KEEP_RESET);
    for (int i = 0; i < tkfs_pkg::MAX_ENTRIES; i++) fit_store[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_KEEP)
        write_keep(DIRECTED_ROWS[i].keep);
      else
        send_beat(DIRECTED_ROWS[i].fit, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].chk,
                  DIRECTED_ROWS[i].typed);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_keep(PHASE_KEEP[p]);
      // Hold the ranked side off so the block fills and refuses entries
      if (p == 0) hold_request = 1'b1;
      if (p == 5) no_idle = 1'b1;
      phase_beats = 0;
      while (phase_beats < SET_BEATS) begin
        sel = $urandom_range(0, 99);
        if (sel < 60)
          len = $urandom_range(1, 6);
        else if (sel < 90)
          len = $urandom_range(7, 20);
        else if (sel < 96)
          len = $urandom_range(21, 32);
        else
          len = $urandom_range(33, 36);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0:       fit = 32'h7FFF_FFFF;
            1:       fit = 32'h8000_0000;
            2, 3:    fit = ($urandom_range(0, 3) << 16) - 32'h0002_0000;
            4:       fit = {tkfs_pkg::FIT_W{$urandom_range(0, 1) == 1}};
            default: fit = $urandom;
          endcase
          send_beat(fit, (i == len - 1), CHK_PREDICT, '0);
        end
        phase_beats += len;
      end
      no_idle = 1'b0;
      if (p == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d entry beats in %0d sets (%0d dropped on a full store), %0d keep writes.",
             beats_sent, sets_sent, dropped_beats, keeps_written);
    $display("Checked %0d rank beats: %0d mismatches, %0d ranks still outstanding.",
             ranks_checked, mismatch_count, expected_ranks.size());
    if (mismatch_count == 0 && expected_ranks.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/tkfs_pkg.sv
design/tkfs_if.sv
design/tkfs_ram.sv
design/tkfs_ctrl.sv
design/tkfs_datapath.sv
design/top_k_fitness_selector_core.sv
verif/top_k_fitness_selector_core_tb.sv
